>>> rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants
// Item and result payloads, classified item, failure and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

	localparam int unsigned LETTER_W = 5;
	localparam logic [7:0] LETTER_BASE = 8'd97;

	// failure code of the word in progress
	localparam logic [1:0] FAIL_NONE    = 2'd0;
	localparam logic [1:0] FAIL_INVALID = 2'd1;
	localparam logic [1:0] FAIL_FULL    = 2'd2;
	localparam logic [1:0] FAIL_MISS    = 2'd3;

	// status field of a result
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
		logic       no_char;
		logic       last_char;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [1:0] status;
	} rsp_t;

	// item after classification by the front end
	typedef struct packed {
		logic                is_search;
		logic                bad;
		logic [LETTER_W-1:0] letter;
		logic                no_char;
		logic                last;
	} item_t;

endpackage

`default_nettype wire

>>> rtl/tws_fifo.sv
// ----------------------------------------------------------------------------
// tws_fifo: small register queue
// First-in first-out queue of DEPTH entries, head shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/tws_front.sv
// ----------------------------------------------------------------------------
// tws_front: item intake
// Classifies each incoming byte (letter index, invalid flag) and queues it
// for the trie walker.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_front #(
	parameter int unsigned ALPHABET = 26
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tws_pkg::req_t  req,
	output logic                full,
	input  wire logic           pop,
	output tws_pkg::item_t      item,
	output logic                empty
);

	import tws_pkg::*;

	logic [7:0] diff;
	item_t      cls;
	logic [$bits(item_t)-1:0] head;

	assign diff          = req.char_code - LETTER_BASE;
	assign cls.is_search = req.req_type;
	assign cls.bad       = (req.char_code < LETTER_BASE) || (diff >= 8'(ALPHABET));
	assign cls.letter    = diff[LETTER_W-1:0];
	assign cls.no_char   = req.no_char;
	assign cls.last      = req.last_char;

	tws_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (pop),
		.rdata (head),
		.empty (empty)
	);

	assign item = item_t'(head);

endmodule

`default_nettype wire

>>> rtl/tws_back.sv
// ----------------------------------------------------------------------------
// tws_back: trie walker
// Holds the child table and word-end flags, walks or extends the trie one
// byte at a time and builds one result per word.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_back #(
	parameter int unsigned NODES    = 1024,
	parameter int unsigned ALPHABET = 26
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_empty,
	input  wire tws_pkg::item_t item,
	output logic                item_pop,
	input  wire logic           rsp_full,
	output logic                rsp_push,
	output tws_pkg::rsp_t       rsp,
	output logic                clearing
);

	import tws_pkg::*;

	localparam int unsigned NW    = $clog2(NODES);
	localparam int unsigned DEPTH = NODES * ALPHABET;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_FETCH   = 3'b001,
		ST_RESOLVE = 3'b010,
		ST_FINISH  = 3'b100
	} state_t;

	logic [NW-1:0] child_mem [DEPTH];
	logic          flag_mem  [NODES];

	state_t        state_q, state_d;
	logic [NW-1:0] node_q, node_d;
	logic [1:0]    fail_q, fail_d;
	logic [NW:0]   next_free_q, next_free_d;
	logic          clearing_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_s1;
	logic [NW-1:0] child_rd_q;
	logic          flag_rd_q;

	logic          walk;
	logic          alloc;
	logic [NW-1:0] nn;
	logic          child_re, child_we;
	logic [AW-1:0] child_raddr, child_waddr;
	logic [NW-1:0] child_wdata;
	logic          flag_re, flag_we;
	logic [NW-1:0] flag_raddr, flag_waddr;
	logic          flag_wdata;

	assign clearing    = clearing_q;
	assign child_raddr = AW'(node_q) * AW'(ALPHABET) + AW'(item.letter);

	always_comb begin
		state_d     = state_q;
		node_d      = node_q;
		fail_d      = fail_q;
		next_free_d = next_free_q;
		item_pop    = 1'b0;
		child_re    = 1'b0;
		child_we    = 1'b0;
		child_waddr = addr_s1;
		child_wdata = next_free_q[NW-1:0];
		flag_re     = 1'b0;
		flag_raddr  = node_q;
		flag_we     = 1'b0;
		flag_waddr  = node_q;
		flag_wdata  = 1'b1;
		rsp_push    = 1'b0;
		rsp.found   = 1'b0;
		rsp.status  = STATUS_OK;
		walk        = !item.no_char && (fail_q == FAIL_NONE);
		alloc       = 1'b0;
		nn          = node_q;

		unique case (state_q)
			ST_FETCH: begin
				if (!clearing_q && !item_empty) begin
					if (walk && !item.bad) begin
						child_re = 1'b1;
						state_d  = ST_RESOLVE;
					end else begin
						if (walk) begin
							fail_d = FAIL_INVALID;
						end
						if (item.last) begin
							flag_re = 1'b1;
							state_d = ST_FINISH;
						end else begin
							item_pop = 1'b1;
						end
					end
				end
			end
			ST_RESOLVE: begin
				if (child_rd_q != '0) begin
					nn = child_rd_q;
				end else if (item.is_search) begin
					fail_d = FAIL_MISS;
				end else if (next_free_q == (NW+1)'(NODES)) begin
					fail_d = FAIL_FULL;
				end else begin
					alloc       = 1'b1;
					child_we    = 1'b1;
					nn          = next_free_q[NW-1:0];
					next_free_d = next_free_q + 1'b1;
				end
				node_d = nn;
				if (item.last) begin
					flag_re    = 1'b1;
					flag_raddr = nn;
					state_d    = ST_FINISH;
				end else begin
					item_pop = 1'b1;
					state_d  = ST_FETCH;
				end
			end
			ST_FINISH: begin
				if (!rsp_full) begin
					rsp_push = 1'b1;
					item_pop = 1'b1;
					if (fail_q == FAIL_NONE) begin
						if (item.is_search) begin
							rsp.found = flag_rd_q;
						end else begin
							flag_we   = 1'b1;
							rsp.found = 1'b1;
						end
					end else begin
						case (fail_q)
							FAIL_INVALID: rsp.status = STATUS_INVALID;
							FAIL_FULL:    rsp.status = STATUS_FULL;
							default:      rsp.status = STATUS_OK;
						endcase
					end
					node_d  = '0;
					fail_d  = FAIL_NONE;
					state_d = ST_FETCH;
				end
			end
			default: state_d = ST_FETCH;
		endcase

		// post-reset sweep owns both write ports
		if (clearing_q) begin
			child_we    = 1'b1;
			child_waddr = clr_q;
			child_wdata = '0;
			flag_we     = ({1'b0, clr_q} < (AW+1)'(NODES));
			flag_waddr  = clr_q[NW-1:0];
			flag_wdata  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FETCH;
			node_q      <= '0;
			fail_q      <= FAIL_NONE;
			next_free_q <= (NW+1)'(1);
			clearing_q  <= 1'b1;
			clr_q       <= '0;
		end else begin
			state_q     <= state_d;
			node_q      <= node_d;
			fail_q      <= fail_d;
			next_free_q <= next_free_d;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (child_re) begin
			addr_s1    <= child_raddr;
			child_rd_q <= child_mem[child_raddr];
		end
		if (child_we) begin
			child_mem[child_waddr] <= child_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (flag_re) begin
			flag_rd_q <= flag_mem[flag_raddr];
		end
		if (flag_we) begin
			flag_mem[flag_waddr] <= flag_wdata;
		end
	end

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != '0) && (next_free_q <= (NW+1)'(NODES)))
		else $error("node pool counter out of range");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> (next_free_q == $past(next_free_q) + 1'b1))
		else $error("allocation did not advance pool counter");

	a_word_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push |=> (node_q == '0) && (fail_q == FAIL_NONE))
		else $error("walk state not returned to root after result");

	a_idle_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !child_re && !item_pop && !rsp_push)
		else $error("trie activity during clearing sweep");

endmodule

`default_nettype wire

>>> rtl/trie_word_insert_search.sv
// ----------------------------------------------------------------------------
// trie_word_insert_search: prefix trie insert and lookup
// Words arrive one byte per item; one result item per word on its last item.
// ----------------------------------------------------------------------------
//  channel   handshake      payload          direction
//  request   push / full    req  (req_t)     in
//  result    pop  / empty   rsp  (rsp_t)     out
//
//  A byte takes a child-table read, then resolve (follow or
//  allocate). The last item of a word adds a word-end flag read.
//  An item without a valid byte, or after the word has failed, skips both.
//  After reset a sweep zeroes both tables, with full held high. A full
//  result queue stalls only the walker; two request items still queue in
//  front.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_insert_search #(
	parameter int unsigned NODES    = 1024,
	parameter int unsigned ALPHABET = 26
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tws_pkg::req_t req,
	output logic               full,
	input  wire logic          pop,
	output tws_pkg::rsp_t      rsp,
	output logic               empty
);

	import tws_pkg::*;

	logic  front_full;
	logic  item_empty;
	logic  item_pop;
	item_t item;
	logic  rsp_full;
	logic  rsp_push;
	rsp_t  rsp_new;
	logic  clearing;
	logic [$bits(rsp_t)-1:0] rsp_head;

	assign full = front_full || clearing;

	tws_front #(
		.ALPHABET(ALPHABET)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !clearing),
		.req   (req),
		.full  (front_full),
		.pop   (item_pop),
		.item  (item),
		.empty (item_empty)
	);

	tws_back #(
		.NODES   (NODES),
		.ALPHABET(ALPHABET)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_empty(item_empty),
		.item      (item),
		.item_pop  (item_pop),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push),
		.rsp       (rsp_new),
		.clearing  (clearing)
	);

	tws_fifo #(
		.WIDTH($bits(rsp_t)),
		.DEPTH(2)
	) u_rsp_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rsp_push),
		.wdata (rsp_new),
		.full  (rsp_full),
		.pop   (pop),
		.rdata (rsp_head),
		.empty (empty)
	);

	assign rsp = rsp_t'(rsp_head);

endmodule

`default_nettype wire
